// ===== rtl/stepper_step_dir_position_control_unit_macros.svh =====
// ----------------------------------------------------------------------------
// stepper step/dir position control unit - assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_DIR_POSITION_CONTROL_UNIT_MACROS_SVH
`define STEPPER_STEP_DIR_POSITION_CONTROL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("stp assertion failed");

// next-cycle implication
`define STP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("stp assertion failed");

`else

`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// shared types and constants of the stepper step/dir position control unit
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

	localparam int POSITION_BITS_DEF = 20;
	localparam int CMP_W             = 33;
	localparam int DEG_W             = 16;
	localparam int SPD_W             = 24;
	localparam int PROD_W            = DEG_W + SPD_W;
	localparam int CONV_SHIFT        = 23;
	localparam int RAW_STEPS_W       = PROD_W - CONV_SHIFT;
	localparam int CNT_W             = 20;
	localparam int POS_OUT_W         = 20;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 24;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (CONV_SHIFT - 1);

	localparam logic [SPD_W-1:0] SPD_RESET        = SPD_W'(36409);
	localparam logic [CNT_W-1:0] MAX_POS_RESET    = CNT_W'(200);
	localparam logic [CNT_W-1:0] PERIOD_RESET     = CNT_W'(4000);
	localparam logic [CNT_W-1:0] PULSE_RESET      = CNT_W'(100);

	localparam logic MODE_TICK       = 1'b0;
	localparam logic MODE_SET_TARGET = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEPS_PER_DEGREE  = 2'd0,
		CFG_MAX_POSITION      = 2'd1,
		CFG_STEP_PERIOD_TICKS = 2'd2,
		CFG_PULSE_WIDTH_TICKS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             mode;
		logic [DEG_W-1:0] target_degrees;
	} stp_in_t;

	typedef struct packed {
		logic                 step_out;
		logic                 dir_out;
		logic [POS_OUT_W-1:0] position;
		logic                 moving;
		logic                 target_accepted;
	} stp_out_t;

endpackage

`default_nettype wire

// ===== rtl/stp_stream_if.sv =====
// ----------------------------------------------------------------------------
// stp_stream_if
// valid/ready item channel with a typed payload
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// stp_cfg_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_cfg_if;
	import stp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stp_conv.sv =====
// ----------------------------------------------------------------------------
// stp_conv
// angle to step count: degrees times steps per degree, rounded, shifted
// ----------------------------------------------------------------------------
`default_nettype none

module stp_conv (
	input  logic [stp_pkg::DEG_W-1:0]       target_degrees,
	input  logic [stp_pkg::SPD_W-1:0]       steps_per_degree,
	output logic [stp_pkg::RAW_STEPS_W-1:0] raw_steps
);
	import stp_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] rounded;

	assign prod      = PROD_W'(target_degrees) * PROD_W'(steps_per_degree);
	assign rounded   = prod + ROUND_HALF;
	assign raw_steps = rounded[PROD_W-1:CONV_SHIFT];

endmodule

`default_nettype wire

// ===== rtl/stepper_step_dir_position_control_unit.sv =====
// path: an accepted item passes the input register, then the result
//   register, from which its result can be taken
// throughput: one item per cycle while result is not stalled; the next
//   motion state is computed combinationally, so each item sees the state left by the last
// reset: asynchronous, clears position, target, timers and pipeline valids,
//   and returns the registers to their default values
// ----------------------------------------------------------------------------
// stepper_step_dir_position_control_unit
// step/direction generator with set-target conversion and tick-driven timers
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_step_dir_position_control_unit_macros.svh"

module stepper_step_dir_position_control_unit #(
	parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	stp_stream_if.sink   item_in,
	stp_stream_if.source result,
	stp_cfg_if.sink      cfg
);
	import stp_pkg::*;

	localparam logic [CMP_W-1:0] POS_MAX = (CMP_W'(1) << POSITION_BITS) - CMP_W'(1);

	// configuration registers
	logic [SPD_W-1:0] spd_q;
	logic [CNT_W-1:0] max_pos_q;
	logic [CNT_W-1:0] period_ticks_q;
	logic [CNT_W-1:0] pulse_ticks_q;

	// input stage
	logic                   valid_s1;
	logic                   mode_s1;
	logic [RAW_STEPS_W-1:0] steps_s1;
	logic [RAW_STEPS_W-1:0] conv_steps;

	// motion state
	logic [POSITION_BITS-1:0] cur_q;
	logic [POSITION_BITS-1:0] tgt_q;
	logic                     active_q;
	logic [CNT_W-1:0]         period_q;
	logic [CNT_W-1:0]         pulse_q;
	logic                     step_q;
	logic                     dir_q;

	logic [POSITION_BITS-1:0] cur_n;
	logic [POSITION_BITS-1:0] tgt_n;
	logic                     active_n;
	logic [CNT_W-1:0]         period_n;
	logic [CNT_W-1:0]         pulse_n;
	logic                     step_n;
	logic                     dir_n;
	logic                     accepted_n;

	logic [CMP_W-1:0] sat_steps;
	logic [CMP_W-1:0] pos_ext;
	logic [CNT_W-1:0] period_reload;
	logic [CNT_W-1:0] pulse_reload;

	// output stage
	logic     out_valid_q;
	stp_out_t out_data_q;
	stp_out_t out_n;

	logic adv_s1;
	logic in_fire;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q          <= SPD_RESET;
			max_pos_q      <= MAX_POS_RESET;
			period_ticks_q <= PERIOD_RESET;
			pulse_ticks_q  <= PULSE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_STEPS_PER_DEGREE:  spd_q          <= cfg.data[SPD_W-1:0];
				CFG_MAX_POSITION:      max_pos_q      <= cfg.data[CNT_W-1:0];
				CFG_STEP_PERIOD_TICKS: period_ticks_q <= cfg.data[CNT_W-1:0];
				CFG_PULSE_WIDTH_TICKS: pulse_ticks_q  <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1        = valid_s1 && (!out_valid_q || result.ready);
	assign item_in.ready = !valid_s1 || adv_s1;
	assign in_fire       = item_in.valid && item_in.ready;

	stp_conv u_conv (
		.target_degrees   (item_in.data.target_degrees),
		.steps_per_degree (spd_q),
		.raw_steps        (conv_steps)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1  <= item_in.data.mode;
			steps_s1 <= conv_steps;
		end
	end

	// motion update
	assign period_reload = (period_ticks_q == '0) ? CNT_W'(1) : period_ticks_q;
	assign pulse_reload  = (pulse_ticks_q == '0) ? CNT_W'(1) : pulse_ticks_q;

	always_comb begin
		cur_n      = cur_q;
		tgt_n      = tgt_q;
		active_n   = active_q;
		period_n   = period_q;
		pulse_n    = pulse_q;
		step_n     = step_q;
		dir_n      = dir_q;
		accepted_n = 1'b0;
		sat_steps  = (CMP_W'(steps_s1) > POS_MAX) ? POS_MAX : CMP_W'(steps_s1);
		if (mode_s1 == MODE_SET_TARGET) begin
			if (sat_steps <= CMP_W'(max_pos_q)) begin
				tgt_n      = sat_steps[POSITION_BITS-1:0];
				accepted_n = 1'b1;
			end
			if ((tgt_n != cur_q) && !active_q) begin
				active_n = 1'b1;
				period_n = period_reload;
			end
		end else begin
			if (pulse_q != '0) begin
				pulse_n = pulse_q - CNT_W'(1);
				if (pulse_n == '0) begin
					step_n = 1'b0;
				end
			end
			if (active_q) begin
				if (period_q <= CNT_W'(1)) begin
					period_n = period_reload;
					if (tgt_q > cur_q) begin
						dir_n   = 1'b1;
						cur_n   = cur_q + POSITION_BITS'(1);
						step_n  = 1'b1;
						pulse_n = pulse_reload;
					end else if (tgt_q < cur_q) begin
						dir_n   = 1'b0;
						cur_n   = cur_q - POSITION_BITS'(1);
						step_n  = 1'b1;
						pulse_n = pulse_reload;
					end else begin
						active_n = 1'b0;
						period_n = '0;
					end
				end else begin
					period_n = period_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			tgt_q    <= '0;
			active_q <= 1'b0;
			period_q <= '0;
			pulse_q  <= '0;
			step_q   <= 1'b0;
			dir_q    <= 1'b0;
		end else if (adv_s1) begin
			cur_q    <= cur_n;
			tgt_q    <= tgt_n;
			active_q <= active_n;
			period_q <= period_n;
			pulse_q  <= pulse_n;
			step_q   <= step_n;
			dir_q    <= dir_n;
		end
	end

	// result register
	assign pos_ext = CMP_W'(cur_n);

	always_comb begin
		out_n.step_out        = step_n;
		out_n.dir_out         = dir_n;
		out_n.position        = pos_ext[POS_OUT_W-1:0];
		out_n.moving          = active_n;
		out_n.target_accepted = accepted_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= out_n;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// checks
	`STP_ASSERT_IMP(a_idle_period_clear, clk, arst_n, !active_q, period_q == '0)
	`STP_ASSERT_IMP(a_step_tracks_pulse, clk, arst_n, 1'b1, step_q == (pulse_q != '0))
	`STP_ASSERT_NXT(a_move_raises_step, clk, arst_n, adv_s1 && (cur_n != cur_q), step_q && out_valid_q)
	`STP_ASSERT_NXT(a_state_holds, clk, arst_n, !adv_s1, $stable(cur_q) && $stable(tgt_q))

endmodule

`default_nettype wire
